### sv/bpu_pkg.sv
// ----------------------------------------------------------------------------
// bpu_pkg
// Shared constants, types and helpers for the posterior update block.
// ----------------------------------------------------------------------------
package bpu_pkg;

  localparam int ENTRIES       = 32;
  localparam int FRACTION_BITS = 24;

  localparam int AW     = $clog2(ENTRIES);       // memory address
  localparam int CW     = $clog2(ENTRIES + 1);   // element count, 0..ENTRIES
  localparam int WORD_W = 32;
  localparam int LIK_W  = 17;
  localparam int PW_W   = 16;
  localparam int IDX_W  = 6;
  localparam int PROB_W = 25;
  localparam int QW     = FRACTION_BITS + 1;     // quotient never exceeds 2^FRACTION_BITS
  localparam int DCW    = $clog2(FRACTION_BITS + 1);

  localparam logic [LIK_W-1:0]  LIK_ONE  = LIK_W'(65536);
  localparam logic [PROB_W-1:0] PROB_MAX = '1;

  // answer codes
  localparam logic [1:0] ANS_YES = 2'd0;
  localparam logic [1:0] ANS_NO  = 2'd1;

  // posterior memory write request
  typedef struct packed {
    logic              en;
    logic [AW-1:0]     addr;
    logic [WORD_W-1:0] data;
  } bpu_wr_t;

  function automatic logic [PROB_W-1:0] clip_prob(input logic [WORD_W-1:0] v);
    logic [PROB_W-1:0] r;
    if (v > WORD_W'(PROB_MAX)) begin
      r = PROB_MAX;
    end else begin
      r = v[PROB_W-1:0];
    end
    return r;
  endfunction

endpackage

### sv/bpu_post_mem.sv
// ----------------------------------------------------------------------------
// bpu_post_mem
// Posterior store: one write port, one registered read port. Entries never
// written since reset read as zero.
// ----------------------------------------------------------------------------
module bpu_post_mem (
  input  logic                          clk,
  input  logic                          rst,
  input  bpu_pkg::bpu_wr_t              wr,
  input  logic                          rd_en,
  input  logic [bpu_pkg::AW-1:0]        rd_addr,
  output logic [bpu_pkg::WORD_W-1:0]    rd_data
);

  logic [bpu_pkg::WORD_W-1:0] mem [bpu_pkg::ENTRIES];
  logic [bpu_pkg::ENTRIES-1:0] vld;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= vld[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wr.addr] <= 1'b1;
    end
  end

endmodule

### sv/bpu_div.sv
// ----------------------------------------------------------------------------
// bpu_div
// Restoring divider, one quotient bit per cycle. Computes
// (dividend << FRACTION_BITS) / divisor for dividend <= divisor.
// ----------------------------------------------------------------------------
module bpu_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [bpu_pkg::WORD_W-1:0]    dividend,
  input  logic [bpu_pkg::WORD_W-1:0]    divisor,
  output logic                          done,
  output logic [bpu_pkg::QW-1:0]        quotient
);

  logic                          busy;
  logic [bpu_pkg::DCW-1:0]       cnt;
  logic [bpu_pkg::WORD_W-1:0]    rem;
  logic [bpu_pkg::WORD_W-1:0]    dsr;
  logic [bpu_pkg::WORD_W:0]      r2;
  logic [bpu_pkg::WORD_W:0]      r2_sub;
  logic                          qbit;
  logic                          first;

  assign done = busy && (cnt == '0);

  always_comb begin
    r2     = {rem, 1'b0};
    r2_sub = r2 - {1'b0, dsr};
    qbit   = (r2 >= {1'b0, dsr});
    first  = (dividend >= divisor);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= bpu_pkg::DCW'(bpu_pkg::FRACTION_BITS);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= first ? (dividend - divisor) : dividend;
      dsr      <= divisor;
      quotient <= bpu_pkg::QW'(first);
    end else if (busy && (cnt != '0)) begin
      rem      <= qbit ? r2_sub[bpu_pkg::WORD_W-1:0] : r2[bpu_pkg::WORD_W-1:0];
      quotient <= {quotient[bpu_pkg::QW-2:0], qbit};
    end
  end

endmodule

### sv/bayes_posterior_update_argmax_top.sv
// ----------------------------------------------------------------------------
// bayes_posterior_update_argmax_top
// Naive Bayes posterior update with argmax over a fixed-point vector.
// ----------------------------------------------------------------------------
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------------------
//   in      | in_valid / in_stall | mode answer prior_weight likelihood_yes
//           |                     | likelihood_no last
//   out     | out_valid/out_stall | entry_index probability best_index
//           |                     | best_valid best_probability sum_was_zero
//           |                     | last_res
//
// Flow: an item takes a memory read, then a multiply (the write-back of the
// entry overlaps the next item's read). The item marked last adds a closing
// step; then, unless no entry was counted or the last item updates nothing,
// the normalize pass runs per entry: read, data back, divide, emit (no divide
// when the sum is zero).
// Reset: rst is synchronous; the posterior store reads as all zero after it.
// Stalls: out_stall holds the normalize pass at the emit step; in_stall is
// high whenever the block is not waiting for an item.
// ----------------------------------------------------------------------------
module bayes_posterior_update_argmax_top (
  input  logic                               clk,
  input  logic                               rst,
  // item input
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               mode,
  input  logic [1:0]                         answer,
  input  logic [bpu_pkg::PW_W-1:0]           prior_weight,
  input  logic [bpu_pkg::LIK_W-1:0]          likelihood_yes,
  input  logic [bpu_pkg::LIK_W-1:0]          likelihood_no,
  input  logic                               last,
  // result output
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [bpu_pkg::IDX_W-1:0]          entry_index,
  output logic [bpu_pkg::PROB_W-1:0]         probability,
  output logic [bpu_pkg::IDX_W-1:0]          best_index,
  output logic                               best_valid,
  output logic [bpu_pkg::PROB_W-1:0]         best_probability,
  output logic                               sum_was_zero,
  output logic                               last_res
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,  // wait for item, read its entry
    S_MUL  = 7'b0000010,  // scale entry, queue write-back
    S_FIN  = 7'b0000100,  // close the run
    S_NRD  = 7'b0001000,  // normalize: read entry
    S_NDAT = 7'b0010000,  // entry data back, start divide if sum nonzero
    S_NDIV = 7'b0100000,  // wait for quotient
    S_NOUT = 7'b1000000   // emit result, write back
  } state_t;

  state_t state, state_next;

  // latched item
  logic                          it_mode;
  logic [1:0]                    it_answer;
  logic [bpu_pkg::PW_W-1:0]      it_pw;
  logic [bpu_pkg::LIK_W-1:0]     it_ly;
  logic [bpu_pkg::LIK_W-1:0]     it_ln;
  logic                          it_last;

  // run state
  logic [bpu_pkg::CW-1:0]        count;
  logic [bpu_pkg::WORD_W-1:0]    run_sum;
  logic                          pend;
  logic [bpu_pkg::AW-1:0]        pend_addr;
  logic [bpu_pkg::WORD_W-1:0]    pend_data;

  // normalize pass
  logic [bpu_pkg::CW-1:0]        n_run;
  logic [bpu_pkg::CW-1:0]        idx;
  logic [bpu_pkg::WORD_W-1:0]    norm_sum;
  logic                          zero_sum;
  logic [bpu_pkg::WORD_W-1:0]    ent_val;
  logic [bpu_pkg::WORD_W-1:0]    best_v;
  logic [bpu_pkg::AW-1:0]        best_i;
  logic                          found;

  // datapath wires
  bpu_pkg::bpu_wr_t              mem_wr;
  logic                          mem_re;
  logic [bpu_pkg::AW-1:0]        mem_raddr;
  logic [bpu_pkg::WORD_W-1:0]    mem_rdata;
  logic                          div_start;
  logic                          div_done;
  logic [bpu_pkg::QW-1:0]        div_q;

  logic                          in_acc;
  logic                          has_slot;
  logic [bpu_pkg::LIK_W-1:0]     lik;
  logic [bpu_pkg::LIK_W-1:0]     lik_sat;
  logic [bpu_pkg::WORD_W+bpu_pkg::LIK_W-1:0] prod;
  logic [bpu_pkg::WORD_W-1:0]    v_new;
  logic [bpu_pkg::WORD_W:0]      sum_wide;
  logic [bpu_pkg::WORD_W-1:0]    sum_commit;
  logic                          no_update;
  logic                          out_free;
  logic                          emit;
  logic                          fin_ent;
  logic                          take_best;
  logic [bpu_pkg::WORD_W-1:0]    best_v_upd;
  logic [bpu_pkg::AW-1:0]        best_i_upd;
  logic                          found_upd;

  bpu_post_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr      (mem_wr),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  bpu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mem_rdata),
    .divisor  (norm_sum),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign has_slot = (count < bpu_pkg::CW'(bpu_pkg::ENTRIES));
  assign no_update = it_mode && it_answer[1];

  // entry update: likelihood capped at one, product truncated by 16 bits
  always_comb begin
    lik     = (it_answer == bpu_pkg::ANS_YES) ? it_ly : it_ln;
    lik_sat = (lik > bpu_pkg::LIK_ONE) ? bpu_pkg::LIK_ONE : lik;
    prod    = mem_rdata * lik_sat;
    if (!it_mode) begin
      v_new = bpu_pkg::WORD_W'(it_pw);
    end else if (it_answer == bpu_pkg::ANS_YES || it_answer == bpu_pkg::ANS_NO) begin
      v_new = prod[bpu_pkg::WORD_W+15:16];
    end else begin
      v_new = mem_rdata;
    end
  end

  // saturating sum including the queued write-back
  always_comb begin
    sum_wide = {1'b0, run_sum} + {1'b0, pend_data};
    if (!pend) begin
      sum_commit = run_sum;
    end else if (sum_wide[bpu_pkg::WORD_W]) begin
      sum_commit = '1;
    end else begin
      sum_commit = sum_wide[bpu_pkg::WORD_W-1:0];
    end
  end

  // argmax including the entry being emitted; first maximum wins
  always_comb begin
    take_best  = (ent_val > best_v);
    best_v_upd = take_best ? ent_val : best_v;
    best_i_upd = take_best ? idx[bpu_pkg::AW-1:0] : best_i;
    found_upd  = found || take_best;
  end

  assign out_free = !(out_valid && out_stall);
  assign emit     = (state == S_NOUT) && out_free;
  assign fin_ent  = (bpu_pkg::CW'(idx + 1'b1) == n_run);
  assign div_start = (state == S_NDAT) && !zero_sum;

  // memory ports: item reads in IDLE, normalize reads in NRD
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = idx[bpu_pkg::AW-1:0];
    if (state == S_IDLE) begin
      mem_re    = in_acc && has_slot;
      mem_raddr = count[bpu_pkg::AW-1:0];
    end else if (state == S_NRD) begin
      mem_re = 1'b1;
    end
    if (pend) begin
      mem_wr.en   = 1'b1;
      mem_wr.addr = pend_addr;
      mem_wr.data = pend_data;
    end else begin
      mem_wr.en   = emit;
      mem_wr.addr = idx[bpu_pkg::AW-1:0];
      mem_wr.data = ent_val;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          state_next = S_MUL;
        end
      end
      S_MUL:  state_next = it_last ? S_FIN : S_IDLE;
      S_FIN: begin
        if (no_update || count == '0) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_NRD;
        end
      end
      S_NRD:  state_next = S_NDAT;
      S_NDAT: state_next = zero_sum ? S_NOUT : S_NDIV;
      S_NDIV: begin
        if (div_done) begin
          state_next = S_NOUT;
        end
      end
      S_NOUT: begin
        if (emit) begin
          state_next = fin_ent ? S_IDLE : S_NRD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      run_sum   <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
      n_run     <= '0;
      zero_sum  <= 1'b0;
      found     <= 1'b0;
    end else begin
      state   <= state_next;
      pend    <= (state == S_MUL) && has_slot;
      run_sum <= (state == S_FIN) ? '0 : sum_commit;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_MUL: begin
          if (has_slot) begin
            count <= count + 1'b1;
          end
        end
        S_FIN: begin
          n_run    <= count;
          count    <= '0;
          zero_sum <= (sum_commit == '0);
          idx      <= '0;
          found    <= 1'b0;
        end
        S_NOUT: begin
          if (emit) begin
            found     <= found_upd;
            idx       <= idx + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      it_mode   <= mode;
      it_answer <= answer;
      it_pw     <= prior_weight;
      it_ly     <= likelihood_yes;
      it_ln     <= likelihood_no;
      it_last   <= last;
    end
    if (state == S_MUL) begin
      pend_addr <= count[bpu_pkg::AW-1:0];
      pend_data <= v_new;
    end
    if (state == S_FIN) begin
      norm_sum <= sum_commit;
      best_v   <= '0;
      best_i   <= '0;
    end
    if (state == S_NDAT && zero_sum) begin
      ent_val <= mem_rdata;
    end
    if (state == S_NDIV && div_done) begin
      ent_val <= bpu_pkg::WORD_W'(div_q);
    end
    if (emit) begin
      best_v           <= best_v_upd;
      best_i           <= best_i_upd;
      entry_index      <= bpu_pkg::IDX_W'(idx);
      probability      <= bpu_pkg::clip_prob(ent_val);
      best_index       <= fin_ent ? bpu_pkg::IDX_W'(best_i_upd) : '0;
      best_valid       <= fin_ent && found_upd;
      best_probability <= fin_ent ? bpu_pkg::clip_prob(best_v_upd) : '0;
      sum_was_zero     <= zero_sum;
      last_res         <= fin_ent;
    end
  end

endmodule
